// ----- rtl/core/mnve_pkg.sv -----
// mnve_pkg: shared types and constants for the NRPN value encoder
// used by mnve_map, mnve_seq and the top level; no dependencies
`default_nettype none

package mnve_pkg;

   // level format
   localparam int LEVEL_WIDTH     = 18;
   localparam int LEVEL_FRAC_BITS = 16;
   localparam int LVL_W           = LEVEL_FRAC_BITS + 1;
   localparam int VALUE_WIDTH     = 14;
   localparam int PROD_W          = LVL_W + VALUE_WIDTH;

   localparam logic [VALUE_WIDTH-1:0] FULL_SCALE = 14'd16383;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIDI_CHANNEL     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARAMETER_NUMBER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MINIMUM    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MAXIMUM    = 2'd3;
   localparam int CSR_DATA_W = 14;

   // controller numbers of the nrpn sequence
   localparam logic [6:0] CTL_NRPN_MSB = 7'd99;
   localparam logic [6:0] CTL_NRPN_LSB = 7'd98;
   localparam logic [6:0] CTL_DATA_MSB = 7'd6;
   localparam logic [6:0] CTL_DATA_LSB = 7'd38;

   // position of a message within its run
   localparam logic [1:0] MSG_NRPN_MSB = 2'd0;
   localparam logic [1:0] MSG_NRPN_LSB = 2'd1;
   localparam logic [1:0] MSG_DATA_MSB = 2'd2;
   localparam logic [1:0] MSG_DATA_LSB = 2'd3;

   localparam logic [3:0] STATUS_CC = 4'hB;

   typedef struct packed {
      logic [4:0]             midi_channel;
      logic [VALUE_WIDTH-1:0] parameter_number;
      logic [VALUE_WIDTH-1:0] range_minimum;
      logic [VALUE_WIDTH-1:0] range_maximum;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/mnve_map.sv -----
// mnve_map: input register, clamp and range mapping into a mapped-value register
// depends on mnve_pkg
`default_nettype none

module mnve_map (
   input  wire                               clock,
   input  wire                               reset,
   input  mnve_pkg::cfg_type                 cfg,
   input  wire                               req_valid,
   input  wire  [mnve_pkg::LEVEL_WIDTH-1:0]  req_level,
   output logic                              req_stall,
   output logic                              map_valid,
   output logic [mnve_pkg::VALUE_WIDTH-1:0]  map_value,
   input  wire                               map_take
);
   import mnve_pkg::*;

   localparam int CMP_W = (LEVEL_WIDTH > LVL_W) ? LEVEL_WIDTH : LVL_W;
   localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << LEVEL_FRAC_BITS;
   localparam logic [LVL_W-1:0] ONE_LVL = LVL_W'(1) << LEVEL_FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (LEVEL_FRAC_BITS - 1);

   logic                   a_valid_ff, a_valid_in;
   logic [LEVEL_WIDTH-1:0] a_level_ff, a_level_in;
   logic                   b_valid_ff, b_valid_in;
   logic [VALUE_WIDTH-1:0] b_value_ff, b_value_in;
   logic                   a_ready, b_ready;

   logic [LVL_W-1:0]       lvl;
   logic [VALUE_WIDTH-1:0] lo, hi, span, scaled;
   logic [PROD_W-1:0]      prod, rounded;

   function automatic logic req_level_neg(input logic [LEVEL_WIDTH-1:0] v);
      req_level_neg = v[LEVEL_WIDTH-1];
   endfunction

   // stage handshake
   assign b_ready   = !b_valid_ff || map_take;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;
   assign map_valid = b_valid_ff;
   assign map_value = b_value_ff;

   // clamp level to 0..1.0
   always_comb begin
      if (req_level_neg(a_level_ff)) begin
         lvl = '0;
      end else if (CMP_W'(a_level_ff[LEVEL_WIDTH-2:0]) > ONE_CMP) begin
         lvl = ONE_LVL;
      end else begin
         lvl = LVL_W'(a_level_ff[LEVEL_WIDTH-2:0]);
      end
   end

   // effective range, repaired when empty or inverted
   always_comb begin
      if (cfg.range_maximum <= cfg.range_minimum) begin
         lo = '0;
         hi = FULL_SCALE;
      end else begin
         lo = cfg.range_minimum;
         hi = cfg.range_maximum;
      end
      span    = hi - lo;
      prod    = PROD_W'(lvl) * PROD_W'(span);
      rounded = prod + HALF;
      scaled  = rounded[LEVEL_FRAC_BITS +: VALUE_WIDTH];
      b_value_in = lo + scaled;
   end

   // next state of both stages
   always_comb begin
      a_valid_in = a_valid_ff;
      a_level_in = a_level_ff;
      b_valid_in = b_valid_ff;
      if (a_ready) begin
         a_valid_in = req_valid;
         a_level_in = req_level;
      end
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_level_ff <= a_level_in;
      if (b_ready) begin
         b_value_ff <= b_value_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/mnve_seq.sv -----
// mnve_seq: duplicate filter and four-message serializer with output register
// depends on mnve_pkg
`default_nettype none

module mnve_seq (
   input  wire                               clock,
   input  wire                               reset,
   input  mnve_pkg::cfg_type                 cfg,
   input  wire                               map_valid,
   input  wire  [mnve_pkg::VALUE_WIDTH-1:0]  map_value,
   output logic                              map_take,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [7:0]                        rsp_status_byte,
   output logic [6:0]                        rsp_controller_number,
   output logic [6:0]                        rsp_data_value,
   output logic                              rsp_last_of_run
);
   import mnve_pkg::*;

   logic                   busy_ff, busy_in;
   logic [1:0]             idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] prev_ff, prev_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic                   finishing, is_dup;
   logic [4:0]             chan;

   // take a new item when idle or as the last message leaves
   assign finishing = busy_ff && (idx_ff == MSG_DATA_LSB) && !rsp_stall;
   assign map_take  = map_valid && (!busy_ff || finishing);
   assign is_dup    = prev_valid_ff && (map_value == prev_ff);

   always_comb begin
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      if (busy_ff && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == MSG_DATA_LSB) begin
            busy_in = 1'b0;
         end
      end
      if (map_take && !is_dup) begin
         busy_in       = 1'b1;
         idx_in        = MSG_NRPN_MSB;
         value_in      = map_value;
         prev_in       = map_value;
         prev_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         idx_ff        <= MSG_NRPN_MSB;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         idx_ff        <= idx_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
      end
      value_ff <= value_in;
   end

   // channel clamped to 1..16
   always_comb begin
      if (cfg.midi_channel == 5'd0) begin
         chan = 5'd1;
      end else if (cfg.midi_channel > 5'd16) begin
         chan = 5'd16;
      end else begin
         chan = cfg.midi_channel;
      end
   end

   // message fields from the held value, the position and the configuration
   assign rsp_valid       = busy_ff;
   assign rsp_status_byte = {STATUS_CC, 4'(chan - 5'd1)};
   assign rsp_last_of_run = (idx_ff == MSG_DATA_LSB);

   always_comb begin
      unique case (idx_ff)
         MSG_NRPN_MSB: begin
            rsp_controller_number = CTL_NRPN_MSB;
            rsp_data_value        = cfg.parameter_number[13:7];
         end
         MSG_NRPN_LSB: begin
            rsp_controller_number = CTL_NRPN_LSB;
            rsp_data_value        = cfg.parameter_number[6:0];
         end
         MSG_DATA_MSB: begin
            rsp_controller_number = CTL_DATA_MSB;
            rsp_data_value        = value_ff[13:7];
         end
         MSG_DATA_LSB: begin
            rsp_controller_number = CTL_DATA_LSB;
            rsp_data_value        = value_ff[6:0];
         end
         default: begin
            rsp_controller_number = CTL_NRPN_MSB;
            rsp_data_value        = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a fresh value starts a run at the first message
   a_new_run: assert property (@(posedge clock) disable iff (reset)
      map_take && !is_dup |=> rsp_valid && idx_ff == MSG_NRPN_MSB)
      else $error("new value did not start a message run");

   // a stalled message keeps its position
   a_hold_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(idx_ff))
      else $error("message position moved under stall");

   // at the first message of a run the remembered value matches the value being sent
   a_prev_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && idx_ff == MSG_NRPN_MSB |-> prev_valid_ff && prev_ff == value_ff)
      else $error("remembered value differs from value being sent");

   // once a value is sent the memory never forgets it
   a_prev_keep: assert property (@(posedge clock) disable iff (reset)
      !$fell(prev_valid_ff))
      else $error("sent-value flag dropped");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/midi_nrpn_value_encoder_unit.sv -----
// a run's first message appears after the level passes the input, mapped-value and
// serializer state registers; a changed value gives 4 messages, one per cycle unless
// stalled, the next item taken as the last leaves; a repeated value gives nothing and
// items flow one per cycle while the serializer is idle; the 4-message serializer sets
// the sustained rate; mapping is one registered multiply; reset (synchronous) clears
// valid flags and sent-value memory, loads channel 1, parameter 0 and range 0..16383
`default_nettype none

module midi_nrpn_value_encoder_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write,
   input  wire  [mnve_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [mnve_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [mnve_pkg::LEVEL_WIDTH-1:0]   req_level,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [7:0]                         rsp_status_byte,
   output logic [6:0]                         rsp_controller_number,
   output logic [6:0]                         rsp_data_value,
   output logic                               rsp_last_of_run
);
   import mnve_pkg::*;

   cfg_type                cfg_ff;
   logic                   map_valid, map_take;
   logic [VALUE_WIDTH-1:0] map_value;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midi_channel     <= 5'd1;
         cfg_ff.parameter_number <= '0;
         cfg_ff.range_minimum    <= '0;
         cfg_ff.range_maximum    <= FULL_SCALE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIDI_CHANNEL:     cfg_ff.midi_channel     <= csr_wdata[4:0];
            CSR_PARAMETER_NUMBER: cfg_ff.parameter_number <= csr_wdata;
            CSR_RANGE_MINIMUM:    cfg_ff.range_minimum    <= csr_wdata;
            CSR_RANGE_MAXIMUM:    cfg_ff.range_maximum    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // level clamp and range mapping
   mnve_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_level (req_level),
      .req_stall (req_stall),
      .map_valid (map_valid),
      .map_value (map_value),
      .map_take  (map_take)
   );

   // duplicate filter and message serializer
   mnve_seq u_seq (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .map_valid             (map_valid),
      .map_value             (map_value),
      .map_take              (map_take),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status_byte       (rsp_status_byte),
      .rsp_controller_number (rsp_controller_number),
      .rsp_data_value        (rsp_data_value),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- tb/mnve_tb_pkg.sv -----
`timescale 1ns / 100ps
// mnve_tb_pkg: expected-message tracker for the nrpn value encoder testbench
// depends on mnve_pkg for the level format, register indexes and controller codes

package mnve_tb_pkg;
   import mnve_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // one control-change message as it leaves the block
   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] controller_number;
      logic [6:0] data_value;
      logic       last_of_run;
   } nrpn_msg_type;

   class nrpn_run_scoreboard;
      cfg_type                regs;
      logic [VALUE_WIDTH-1:0] last_sent;
      bit                     sent_any;
      logic [7:0]             run_status;
      nrpn_msg_type           pending_msgs[$];
      int unsigned            failures;
      int unsigned            levels_seen;
      int unsigned            repeats;
      int unsigned            runs;
      int unsigned            msgs_checked;

      // register and history values after reset
      function new();
         regs.midi_channel     = 5'd1;
         regs.parameter_number = '0;
         regs.range_minimum    = '0;
         regs.range_maximum    = FULL_SCALE;
         last_sent             = '0;
         sent_any              = 1'b0;
         failures              = 0;
         levels_seen           = 0;
         repeats               = 0;
         runs                  = 0;
         msgs_checked          = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] reg_index,
                                   logic [CSR_DATA_W-1:0] data);
         case (reg_index)
            CSR_MIDI_CHANNEL:     regs.midi_channel     = data[4:0];
            CSR_PARAMETER_NUMBER: regs.parameter_number = data[VALUE_WIDTH-1:0];
            CSR_RANGE_MINIMUM:    regs.range_minimum    = data[VALUE_WIDTH-1:0];
            CSR_RANGE_MAXIMUM:    regs.range_maximum    = data[VALUE_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void queue_msg(logic [6:0] ctl, logic [6:0] data, logic last);
         nrpn_msg_type m;
         m.status_byte       = run_status;
         m.controller_number = ctl;
         m.data_value        = data;
         m.last_of_run       = last;
         pending_msgs.insert(pending_msgs.size(), m);
      endfunction

      // map one accepted level and queue the four messages it should cause, or none for a repeat
      function void encode_level(logic [LEVEL_WIDTH-1:0] level);
         logic [31:0]            one_level;
         logic [31:0]            lvl;
         logic [31:0]            scaled;
         logic [VALUE_WIDTH-1:0] lo;
         logic [VALUE_WIDTH-1:0] hi;
         logic [VALUE_WIDTH-1:0] value;
         logic [4:0]             ch;
         one_level = 32'd1 << LEVEL_FRAC_BITS;
         levels_seen++;
         // clamp to 0..1.0, negatives go to zero
         if (level[LEVEL_WIDTH-1]) begin
            lvl = '0;
         end else if (32'(level) > one_level) begin
            lvl = one_level;
         end else begin
            lvl = 32'(level);
         end
         // empty or inverted range falls back to the full 14-bit span
         lo = regs.range_minimum;
         hi = regs.range_maximum;
         if (hi <= lo) begin
            lo = '0;
            hi = FULL_SCALE;
         end
         scaled = lvl * 32'(hi - lo) + (32'd1 << (LEVEL_FRAC_BITS - 1));
         value  = lo + VALUE_WIDTH'(scaled >> LEVEL_FRAC_BITS);
         // same value as the last one sent gives nothing
         if (sent_any && value == last_sent) begin
            repeats++;
            return;
         end
         last_sent = value;
         sent_any  = 1'b1;
         runs++;
         ch = regs.midi_channel;
         if (ch == 5'd0) begin
            ch = 5'd1;
         end else if (ch > 5'd16) begin
            ch = 5'd16;
         end
         run_status = {STATUS_CC, 4'(ch - 5'd1)};
         queue_msg(CTL_NRPN_MSB, regs.parameter_number[13:7], 1'b0);
         queue_msg(CTL_NRPN_LSB, regs.parameter_number[6:0], 1'b0);
         queue_msg(CTL_DATA_MSB, value[13:7], 1'b0);
         queue_msg(CTL_DATA_LSB, value[6:0], 1'b1);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      // compare one accepted message with the oldest one queued
      function void check_message(logic [7:0] status, logic [6:0] ctl, logic [6:0] data,
                                  logic last);
         nrpn_msg_type got;
         nrpn_msg_type want;
         got = {status, ctl, data, last};
         if (pending_msgs.size() == 0) begin
            note_failure($sformatf("%0t: unexpected message status %02h ctl %0d data %0d last %0d",
                                   $time, status, ctl, data, last));
            return;
         end
         want = pending_msgs.pop_front();
         msgs_checked++;
         if (got.status_byte !== want.status_byte ||
             got.controller_number !== want.controller_number ||
             got.data_value !== want.data_value || got.last_of_run !== want.last_of_run) begin
            note_failure($sformatf({"%0t: message mismatch, expected status %02h ctl %0d ",
                                    "data %0d last %0d, got status %02h ctl %0d data %0d last %0d"},
                                   $time, want.status_byte, want.controller_number,
                                   want.data_value, want.last_of_run, status, ctl, data, last));
         end
      endfunction

      function int unsigned outstanding();
         return pending_msgs.size();
      endfunction

      // anything still queued at the end never arrived
      function void close_out();
         nrpn_msg_type want;
         while (pending_msgs.size() != 0) begin
            want = pending_msgs.pop_front();
            note_failure($sformatf("missing message status %02h ctl %0d data %0d last %0d",
                                   want.status_byte, want.controller_number, want.data_value,
                                   want.last_of_run));
         end
      endfunction
   endclass

endpackage

// ----- tb/tb_midi_nrpn_value_encoder_unit.sv -----
`timescale 1ns / 100ps
// tb_midi_nrpn_value_encoder_unit: self-checking bench for the nrpn value encoder
// depends on mnve_pkg, mnve_tb_pkg and the midi_nrpn_value_encoder_unit rtl

module tb_midi_nrpn_value_encoder_unit;
   import mnve_pkg::*;
   import mnve_tb_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int IDLE_PERCENT    = 23;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int RANDOM_PHASES   = 8;
   localparam int LEVELS_PER_PHASE = 50;
   localparam int QUIET_PHASE     = 3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic [LEVEL_WIDTH-1:0] req_level = '0;
   logic                   rsp_stall = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [7:0]             rsp_status_byte;
   logic [6:0]             rsp_controller_number;
   logic [6:0]             rsp_data_value;
   logic                   rsp_last_of_run;

   bit                     req_idling = 1'b1;
   bit                     rsp_idling = 1'b1;
   int unsigned            idle_cycles = 0;
   int unsigned            settings_loaded = 0;
   nrpn_run_scoreboard     sb;

   midi_nrpn_value_encoder_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_level             (req_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status_byte       (rsp_status_byte),
      .rsp_controller_number (rsp_controller_number),
      .rsp_data_value        (rsp_data_value),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= rsp_idling && ($urandom_range(99) < IDLE_PERCENT);
   end

   // sample both handshakes on the rising edge
   always @(posedge clock) begin : monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.encode_level(req_level);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_message(rsp_status_byte, rsp_controller_number, rsp_data_value,
                             rsp_last_of_run);
            moved = 1'b1;
         end
      end
      if (moved || reset) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
   end

   // watchdog on a stretch with no handshake at all
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: %0d cycles without any item moving", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // present one level and hold it until accepted; valid stays high on return
   task automatic send_level(input logic [LEVEL_WIDTH-1:0] lvl);
      if (req_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid <= 1'b1;
      req_level <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // write all four registers on consecutive cycles
   task automatic load_settings(input logic [CSR_DATA_W-1:0] ch, input logic [CSR_DATA_W-1:0] pn,
                                input logic [CSR_DATA_W-1:0] lo, input logic [CSR_DATA_W-1:0] hi);
      logic [CSR_INDEX_W-1:0] regs_idx [4];
      logic [CSR_DATA_W-1:0]  regs_val [4];
      regs_idx = '{CSR_MIDI_CHANNEL, CSR_PARAMETER_NUMBER, CSR_RANGE_MINIMUM, CSR_RANGE_MAXIMUM};
      regs_val = '{ch, pn, lo, hi};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= regs_idx[i];
         csr_wdata <= regs_val[i];
         sb.write_register(regs_idx[i], regs_val[i]);
         @(negedge clock);
      end
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   // stop sending, let queued messages drain, then give the pipe time to empty
   task automatic wait_quiet();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly in-range levels, with repeats, edges and raw 18-bit noise
   function automatic logic [LEVEL_WIDTH-1:0] pick_level(logic [LEVEL_WIDTH-1:0] prev);
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 15) return prev;
      if (sel < 30) return LEVEL_WIDTH'($urandom);
      if (sel < 40) begin
         case ($urandom_range(7))
            0: return 18'h00000;
            1: return 18'h10000;
            2: return 18'h0FFFF;
            3: return 18'h00001;
            4: return 18'h08000;
            5: return 18'h1FFFF;
            6: return 18'h20000;
            default: return 18'h3FFFF;
         endcase
      end
      return LEVEL_WIDTH'($urandom_range(32'h10000));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0]  ch;
      logic [CSR_DATA_W-1:0]  pn;
      logic [CSR_DATA_W-1:0]  lo;
      logic [CSR_DATA_W-1:0]  hi;
      logic [LEVEL_WIDTH-1:0] lvl;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: first send, repeats, clamping at both ends, rounding
      send_level(18'h00000);
      send_level(18'h00000);
      send_level(18'h20000);
      send_level(18'h10000);
      send_level(18'h1FFFF);
      send_level(18'h08000);
      send_level(18'h00001);
      send_level(18'h0FFFF);
      send_level(18'h3FFFF);
      wait_quiet();

      // channel zero, top parameter number, empty range
      load_settings(14'd0, 14'd16383, 14'd100, 14'd100);
      send_level(18'h10000);
      send_level(18'h00000);
      send_level(18'h08000);
      wait_quiet();

      // channel above sixteen, inverted range
      load_settings(14'd31, 14'h2A55, 14'd16383, 14'd0);
      send_level(18'h10000);
      send_level(18'h10000);
      wait_quiet();

      // one-step range: rounding half up decides the value
      load_settings(14'd17, 14'd127, 14'd0, 14'd1);
      send_level(18'h07FFF);
      send_level(18'h08000);
      send_level(18'h10000);
      send_level(18'h00000);
      wait_quiet();

      // channel sixteen, full span
      load_settings(14'd16, 14'd128, 14'd0, 14'd16383);
      send_level(18'h1FFFF);
      send_level(18'h00000);
      send_level(18'h18000);
      send_level(18'h00010);
      wait_quiet();

      // random phases, one with no idling on either side
      lvl = '0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_idling = (phase != QUIET_PHASE);
         rsp_idling = (phase != QUIET_PHASE);
         ch = ($urandom_range(99) < 70) ? CSR_DATA_W'($urandom_range(16, 1))
                                        : CSR_DATA_W'($urandom_range(31));
         pn = CSR_DATA_W'($urandom_range(16383));
         lo = CSR_DATA_W'($urandom_range(16383));
         case ($urandom_range(3))
            0: hi = CSR_DATA_W'($urandom_range(16383));
            1: hi = (lo > 14'd16380) ? lo : lo + CSR_DATA_W'($urandom_range(3, 1));
            2: begin
               lo = '0;
               hi = FULL_SCALE;
            end
            default: hi = lo + CSR_DATA_W'($urandom_range(16383 - lo));
         endcase
         load_settings(ch, pn, lo, hi);
         for (int n = 0; n < LEVELS_PER_PHASE; n++) begin
            lvl = pick_level(lvl);
            send_level(lvl);
         end
         wait_quiet();
      end

      sb.close_out();
      $display("run covered %0d levels over %0d register settings", sb.levels_seen,
               settings_loaded);
      $display("%0d runs sent, %0d repeated values suppressed, %0d messages compared",
               sb.runs, sb.repeats, sb.msgs_checked);
      if (sb.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mnve_pkg.sv
rtl/core/mnve_map.sv
rtl/core/mnve_seq.sv
rtl/core/midi_nrpn_value_encoder_unit.sv
tb/mnve_tb_pkg.sv
tb/tb_midi_nrpn_value_encoder_unit.sv
